FILE: hw/rtl/pcdin_sentence_parser_macros.svh
// ----------------------------------------------------------------------------
// pcdin_sentence_parser_macros.svh
// Assertion macros used by the PCDIN decode RTL.
// ----------------------------------------------------------------------------
`ifndef PCDIN_SENTENCE_PARSER_MACROS_SVH
`define PCDIN_SENTENCE_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PCDIN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define PCDIN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/pcdin_pkg.sv
// ----------------------------------------------------------------------------
// pcdin_pkg
// Types, constants and helper functions for the PCDIN sentence parser.
// ----------------------------------------------------------------------------
package pcdin_pkg;

    localparam logic [7:0] MAX_DATA_BYTES = 8'd223;

    localparam logic [4:0] LEAD_LEN  = 5'd6;
    localparam logic [4:0] HDR_LEN   = 5'd26;
    localparam logic [7:0] CHAR_STAR = 8'h2A;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_PREFIX    = 3'd1;
    localparam logic [2:0] ST_BAD_HEX   = 3'd2;
    localparam logic [2:0] ST_TRUNC     = 3'd3;
    localparam logic [2:0] ST_ODD_LEN   = 3'd4;
    localparam logic [2:0] ST_TOO_LONG  = 3'd5;
    localparam logic [2:0] ST_CHECKSUM  = 3'd6;

    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_PAYLOAD = 4'b0010,
        PH_CKSUM   = 4'b0100,
        PH_DONE    = 4'b1000
    } pcdin_phase_t;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_sentence;
    } pcdin_item_t;

    typedef struct packed {
        logic        is_summary;
        logic [2:0]  status;
        logic [7:0]  payload_length;
        logic [7:0]  source_address;
        logic [31:0] time_stamp;
        logic [23:0] group_number;
        logic [7:0]  byte_index;
        logic [7:0]  data_byte;
    } pcdin_result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } pcdin_hex_t;

    function automatic pcdin_hex_t hex_decode(input logic [7:0] c);
        pcdin_hex_t h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.value = c[3:0];
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            h.value = c[3:0] + 4'd9;
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    // "$PCDIN"
    function automatic logic [7:0] lead_char(input logic [2:0] p);
        logic [7:0] c;
        unique case (p)
            3'd0:    c = 8'h24;
            3'd1:    c = 8'h50;
            3'd2:    c = 8'h43;
            3'd3:    c = 8'h44;
            3'd4:    c = 8'h49;
            3'd5:    c = 8'h4E;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: hw/rtl/pcdin_in_stage.sv
// ----------------------------------------------------------------------------
// pcdin_in_stage
// Input register: captures one character beat and holds it until decoded.
// ----------------------------------------------------------------------------
module pcdin_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  pcdin_pkg::pcdin_item_t s_item,
    input  logic                 advance,
    output logic                 item_valid,
    output pcdin_pkg::pcdin_item_t item
);
    import pcdin_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    pcdin_item_t item_reg;
    logic        load;

    assign s_tready   = !valid_reg || advance;
    assign load       = s_tvalid && s_tready;
    assign valid_next = load ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: hw/rtl/pcdin_decode.sv
// ----------------------------------------------------------------------------
// pcdin_decode
// Sentence state and per-character decode: header fields, payload bytes,
// checksum and the end-of-sentence summary.
// ----------------------------------------------------------------------------
`include "pcdin_sentence_parser_macros.svh"

module pcdin_decode (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  pcdin_pkg::pcdin_item_t item,
    output logic                   has_result,
    output pcdin_pkg::pcdin_result_t result
);
    import pcdin_pkg::*;

    pcdin_phase_t phase_reg,   phase_next;
    logic [4:0]   pos_reg,     pos_next;
    logic [23:0]  pgn_reg,     pgn_next;
    logic [31:0]  stamp_reg,   stamp_next;
    logic [7:0]   source_reg,  source_next;
    logic [3:0]   high_reg,    high_next;
    logic         odd_reg,     odd_next;
    logic [7:0]   bytes_reg,   bytes_next;
    logic [7:0]   xor_reg,     xor_next;
    logic [7:0]   sent_reg,    sent_next;
    logic [2:0]   herr_reg,    herr_next;
    logic         phex_reg,    phex_next;
    logic         fhex_reg,    fhex_next;
    logic         stop_reg,    stop_next;
    logic         long_reg,    long_next;

    pcdin_hex_t   hx;
    logic [7:0]   c;
    logic         fhex_tmp;
    logic [2:0]   status;

    assign c  = item.character;
    assign hx = hex_decode(c);

    // First failing check wins
    always_comb
    begin
        priority if (phase_reg == PH_HEADER)
        begin
            if (herr_reg != ST_OK)
                status = herr_reg;
            else
                status = (pos_reg < LEAD_LEN) ? ST_PREFIX : ST_TRUNC;
        end
        else if (herr_reg != ST_OK)
            status = herr_reg;
        else if (odd_reg)
            status = ST_ODD_LEN;
        else if (long_reg)
            status = ST_TOO_LONG;
        else if (phex_reg)
            status = ST_BAD_HEX;
        else if (phase_reg != PH_DONE)
            status = ST_TRUNC;
        else if (fhex_reg)
            status = ST_BAD_HEX;
        else if (sent_reg != xor_reg)
            status = ST_CHECKSUM;
        else
            status = ST_OK;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        pgn_next    = pgn_reg;
        stamp_next  = stamp_reg;
        source_next = source_reg;
        high_next   = high_reg;
        odd_next    = odd_reg;
        bytes_next  = bytes_reg;
        xor_next    = xor_reg;
        sent_next   = sent_reg;
        herr_next   = herr_reg;
        phex_next   = phex_reg;
        fhex_next   = fhex_reg;
        stop_next   = stop_reg;
        long_next   = long_reg;
        fhex_tmp    = fhex_reg;
        has_result  = 1'b0;
        result      = '0;

        if (item.end_of_sentence)
        begin
            has_result            = 1'b1;
            result.is_summary     = 1'b1;
            result.group_number   = pgn_reg;
            result.time_stamp     = stamp_reg;
            result.source_address = source_reg;
            result.payload_length = bytes_reg;
            result.status         = status;
            phase_next  = PH_HEADER;
            pos_next    = '0;
            pgn_next    = '0;
            stamp_next  = '0;
            source_next = '0;
            high_next   = '0;
            odd_next    = 1'b0;
            bytes_next  = '0;
            xor_next    = '0;
            sent_next   = '0;
            herr_next   = ST_OK;
            phex_next   = 1'b0;
            fhex_next   = 1'b0;
            stop_next   = 1'b0;
            long_next   = 1'b0;
        end
        else
        begin
            // checksum covers everything after the first character up to '*'
            if (!(phase_reg == PH_HEADER && pos_reg == 5'd0) && !stop_reg)
            begin
                if (c == CHAR_STAR)
                    stop_next = 1'b1;
                else
                    xor_next = xor_reg ^ c;
            end

            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (pos_reg < LEAD_LEN)
                    begin
                        if (c != lead_char(pos_reg[2:0]) && herr_reg == ST_OK)
                            herr_next = ST_PREFIX;
                    end
                    else if (pos_reg != 5'd6 && pos_reg != 5'd13 &&
                             pos_reg != 5'd22 && pos_reg != 5'd25)
                    begin
                        fhex_tmp = fhex_reg || !hx.ok;
                        if (pos_reg <= 5'd12)
                            pgn_next = {pgn_reg[19:0], hx.value};
                        else if (pos_reg <= 5'd21)
                            stamp_next = {stamp_reg[27:0], hx.value};
                        else
                            source_next = {source_reg[3:0], hx.value};
                        // field checkpoints, the PGN one after its first two digits
                        if (pos_reg == 5'd8 || pos_reg == 5'd12 ||
                            pos_reg == 5'd21 || pos_reg == 5'd24)
                        begin
                            if (fhex_tmp && herr_reg == ST_OK)
                                herr_next = ST_BAD_HEX;
                            fhex_tmp = 1'b0;
                        end
                        fhex_next = fhex_tmp;
                    end
                    if (pos_reg == HDR_LEN - 5'd1)
                    begin
                        phase_next = PH_PAYLOAD;
                        pos_next   = '0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 5'd1;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (c == CHAR_STAR)
                    begin
                        phase_next = PH_CKSUM;
                        pos_next   = '0;
                    end
                    else
                    begin
                        if (!hx.ok)
                            phex_next = 1'b1;
                        if (!odd_reg)
                        begin
                            high_next = hx.value;
                            odd_next  = 1'b1;
                        end
                        else
                        begin
                            odd_next = 1'b0;
                            if (bytes_reg >= MAX_DATA_BYTES)
                            begin
                                long_next = 1'b1;
                            end
                            else
                            begin
                                has_result       = 1'b1;
                                result.data_byte  = {high_reg, hx.value};
                                result.byte_index = bytes_reg;
                                bytes_next        = bytes_reg + 8'd1;
                            end
                        end
                    end
                end
                PH_CKSUM:
                begin
                    if (!hx.ok)
                        fhex_next = 1'b1;
                    sent_next = {sent_reg[3:0], hx.value};
                    pos_next  = pos_reg + 5'd1;
                    if (pos_reg != 5'd0)
                        phase_next = PH_DONE;
                end
                PH_DONE:
                begin
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= '0;
            pgn_reg    <= '0;
            stamp_reg  <= '0;
            source_reg <= '0;
            high_reg   <= '0;
            odd_reg    <= 1'b0;
            bytes_reg  <= '0;
            xor_reg    <= '0;
            sent_reg   <= '0;
            herr_reg   <= ST_OK;
            phex_reg   <= 1'b0;
            fhex_reg   <= 1'b0;
            stop_reg   <= 1'b0;
            long_reg   <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            pgn_reg    <= pgn_next;
            stamp_reg  <= stamp_next;
            source_reg <= source_next;
            high_reg   <= high_next;
            odd_reg    <= odd_next;
            bytes_reg  <= bytes_next;
            xor_reg    <= xor_next;
            sent_reg   <= sent_next;
            herr_reg   <= herr_next;
            phex_reg   <= phex_next;
            fhex_reg   <= fhex_next;
            stop_reg   <= stop_next;
            long_reg   <= long_next;
        end
    end

    `PCDIN_ASSERT_NEXT(a_summary_clears, fire && item.end_of_sentence, phase_reg == PH_HEADER && pos_reg == 5'd0 && bytes_reg == 8'd0 && !stop_reg, "state not cleared after summary")
    `PCDIN_ASSERT_NOW(a_bytes_bound, 1'b1, bytes_reg <= MAX_DATA_BYTES, "payload count beyond maximum")
    `PCDIN_ASSERT_NOW(a_header_clean, phase_reg == PH_HEADER, !odd_reg && bytes_reg == 8'd0 && !long_reg, "payload state set during header")

endmodule

FILE: hw/rtl/pcdin_out_stage.sv
// ----------------------------------------------------------------------------
// pcdin_out_stage
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module pcdin_out_stage (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  pcdin_pkg::pcdin_result_t result,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [95:0]              m_tdata,
    output logic                     m_tuser
);
    import pcdin_pkg::*;

    logic          valid_reg;
    logic          valid_next;
    pcdin_result_t res_reg;

    assign valid_next = load ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.is_summary;
    assign m_tdata  = {5'd0, res_reg.status, res_reg.payload_length, res_reg.source_address,
                       res_reg.time_stamp, res_reg.group_number, res_reg.byte_index,
                       res_reg.data_byte};

endmodule

FILE: hw/rtl/pcdin_sentence_parser.sv
// m_tvalid rises when a decoded payload byte or summary is loaded from the input register into the result register.
// Throughput: one character per cycle while m_tready does not stall the pipe; the decode step is combinational logic
// between the input register and the result register.
// Backpressure on m_tready stalls the whole pipe; s_tready drops only when both
// registers are full. Reset (rst_n low, asynchronous) empties both registers and
// returns the sentence state to the start of a new sentence.
// ----------------------------------------------------------------------------
// pcdin_sentence_parser
// Top level: "$PCDIN" sentence decoder, one character per beat in, payload
// bytes and an end-of-sentence summary out.
// ----------------------------------------------------------------------------
module pcdin_sentence_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic        s_tlast,   // end of sentence
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] data_byte, [15:8] byte_index, [39:16] group_number, [71:40] time_stamp,
    // [79:72] source_address, [87:80] payload_length, [90:88] status, rest zero
    output logic [95:0] m_tdata,
    output logic        m_tuser    // is_summary
);
    import pcdin_pkg::*;

    pcdin_item_t   s_item;
    pcdin_item_t   item;
    logic          item_valid;
    logic          advance;
    logic          fire;
    logic          has_result;
    pcdin_result_t result;

    assign s_item.character       = s_tdata;
    assign s_item.end_of_sentence = s_tlast;

    // the pipe moves whenever the result register is free or being emptied
    assign advance = !m_tvalid || m_tready;
    assign fire    = item_valid && advance;

    pcdin_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    pcdin_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .item       (item),
        .has_result (has_result),
        .result     (result)
    );

    pcdin_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire && has_result),
        .result   (result),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
